[rtl/core/u8dc_pkg.sv]
// Shared types, widths and a lead-byte helper for the UTF-8 decoder.
`default_nettype none

package u8dc_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned PAYLOAD_W = 18;

    typedef logic [CP_W-1:0]  cp_t;
    typedef logic [LEN_W-1:0] len_t;

    // Sequence lengths by name
    localparam len_t LEN_NONE = 3'd0;
    localparam len_t LEN_ONE  = 3'd1;
    localparam len_t LEN_TWO  = 3'd2;
    localparam len_t LEN_THREE = 3'd3;
    localparam len_t LEN_FOUR = 3'd4;

    // One decoded codepoint leaving the sequence tracker
    typedef struct packed {
        cp_t  codepoint;
        len_t seq_length;
        logic first_of_text;
        logic last_of_text;
    } u8dc_res_t;

    // Expected sequence length from a lead byte; stray bytes count as one
    function automatic len_t lead_length(input logic [7:0] b);
        len_t len;
        if (b[7] == 1'b0) begin
            len = LEN_ONE;
        end else if (b[7:5] == 3'b110) begin
            len = LEN_TWO;
        end else if (b[7:4] == 4'b1110) begin
            len = LEN_THREE;
        end else if (b[7:3] == 5'b11110) begin
            len = LEN_FOUR;
        end else begin
            len = LEN_ONE;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/core/utf8_decoder_with_case.sv]
// A word that completes a codepoint passes the input register, then the result register, to m_valid.
// Throughput: one byte per cycle; the input register and the result register both
// advance every cycle while m_ready is high, so no byte waits on an earlier one.
// A byte that only opens or extends a sequence produces no result word.
// Reset (aresetn low, synchronous) empties both registers, closes any open
// sequence and marks the next codepoint as the first of a text.
`default_nettype none

module utf8_decoder_with_case (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire [7:0]           s_data_byte,
    input  wire                 s_end_of_text,
    output logic                m_valid,
    input  wire                 m_ready,
    output u8dc_pkg::cp_t       m_codepoint,
    output u8dc_pkg::len_t      m_seq_length,
    output logic                m_is_lower,
    output u8dc_pkg::cp_t       m_upper_codepoint,
    output logic                m_first_of_text,
    output logic                m_last_of_text
);
    import u8dc_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;

    logic       out_valid_reg, out_valid_next;
    u8dc_res_t  out_res_reg;
    logic       out_lower_reg;
    cp_t        out_upper_reg;

    logic       advance;
    logic       emit;
    u8dc_res_t  result;
    logic       res_lower;
    cp_t        res_upper;

    // Move the held word forward when the result register can take it
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    u8dc_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .emit        (emit),
        .result      (result)
    );

    u8dc_case u_case (
        .codepoint       (result.codepoint),
        .is_lower        (res_lower),
        .upper_codepoint (res_upper)
    );

    // Valid flags for both registers
    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input and result words
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eot_reg  <= s_end_of_text;
        end
        if (advance && emit) begin
            out_res_reg   <= result;
            out_lower_reg <= res_lower;
            out_upper_reg <= res_upper;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_codepoint       = out_res_reg.codepoint;
    assign m_seq_length      = out_res_reg.seq_length;
    assign m_is_lower        = out_lower_reg;
    assign m_upper_codepoint = out_upper_reg;
    assign m_first_of_text   = out_res_reg.first_of_text;
    assign m_last_of_text    = out_res_reg.last_of_text;

endmodule

`default_nettype wire

[rtl/core/u8dc_case.sv]
// Latin lower-case detection and upper-case mapping of one codepoint.
`default_nettype none

module u8dc_case (
    input  wire u8dc_pkg::cp_t codepoint,
    output logic               is_lower,
    output u8dc_pkg::cp_t      upper_codepoint
);
    import u8dc_pkg::*;

    logic ascii_lower;
    logic latin1_lower;
    logic ext_a_lower;

    // Classify the three lower-case ranges
    always_comb begin
        ascii_lower  = (codepoint inside {[21'h61 : 21'h7A]});
        latin1_lower = (codepoint inside {[21'hE0 : 21'hFE]}) && (codepoint != 21'hF7);
        ext_a_lower  = (codepoint inside {[21'h100 : 21'h17F]}) && codepoint[0];
    end

    // Map to upper case: subtract 0x20 for ASCII and Latin-1, 1 for Extended-A
    always_comb begin
        is_lower = ascii_lower || latin1_lower || ext_a_lower;
        if (ascii_lower || latin1_lower) begin
            upper_codepoint = codepoint - cp_t'(32);
        end else if (ext_a_lower) begin
            upper_codepoint = codepoint - cp_t'(1);
        end else begin
            upper_codepoint = codepoint;
        end
    end

endmodule

`default_nettype wire

[rtl/core/u8dc_seq.sv]
// Sequence tracker: holds the open UTF-8 sequence and assembles codepoints.
`default_nettype none

module u8dc_seq (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    step,
    input  wire [7:0]              data_byte,
    input  wire                    end_of_text,
    output logic                   emit,
    output u8dc_pkg::u8dc_res_t    result
);
    import u8dc_pkg::*;

    logic [7:0]           held_lead_reg,  held_lead_next;
    logic [PAYLOAD_W-1:0] payload_reg,    payload_next;
    len_t                 bytes_held_reg, bytes_held_next;
    len_t                 expected_reg,   expected_next;
    logic                 at_start_reg,   at_start_next;

    logic                 seq_open;
    len_t                 lead_len;
    len_t                 held_inc;
    logic [PAYLOAD_W-1:0] payload_shift;
    cp_t                  lead_part;
    cp_t                  cp_value;
    len_t                 len_value;

    // Decode one word against the open sequence
    always_comb begin
        seq_open = (bytes_held_reg != LEN_NONE) && (bytes_held_reg <= LEN_THREE)
                   && (expected_reg >= LEN_TWO) && (expected_reg <= LEN_FOUR);
        lead_len      = lead_length(data_byte);
        held_inc      = bytes_held_reg + LEN_ONE;
        payload_shift = {payload_reg[PAYLOAD_W-7:0], data_byte[5:0]};

        case (held_inc)
            LEN_TWO:   lead_part = {10'b0, held_lead_reg[4:0], 6'b0};
            LEN_THREE: lead_part = {5'b0, held_lead_reg[3:0], 12'b0};
            LEN_FOUR:  lead_part = {held_lead_reg[2:0], 18'b0};
            default:   lead_part = '0;
        endcase

        held_lead_next  = held_lead_reg;
        payload_next    = payload_reg;
        bytes_held_next = bytes_held_reg;
        expected_next   = expected_reg;
        at_start_next   = at_start_reg;
        emit            = 1'b0;
        cp_value        = {13'b0, data_byte};
        len_value       = LEN_ONE;

        if (!seq_open) begin
            // Lead byte: emit single-byte words and remnants raw, else open
            if ((lead_len == LEN_ONE) || end_of_text) begin
                emit = 1'b1;
            end else begin
                held_lead_next  = data_byte;
                payload_next    = '0;
                bytes_held_next = LEN_ONE;
                expected_next   = lead_len;
            end
        end else begin
            // Continuation: gather six bits, close on full length or end of text
            payload_next    = payload_shift;
            bytes_held_next = held_inc;
            if ((held_inc >= expected_reg) || end_of_text) begin
                emit      = 1'b1;
                cp_value  = lead_part | {3'b0, payload_shift};
                len_value = held_inc;
            end
        end

        if (emit) begin
            held_lead_next  = '0;
            payload_next    = '0;
            bytes_held_next = LEN_NONE;
            expected_next   = LEN_NONE;
            at_start_next   = end_of_text;
        end

        result.codepoint     = cp_value;
        result.seq_length    = len_value;
        result.first_of_text = at_start_reg;
        result.last_of_text  = end_of_text;
    end

    // Advance sequence state on each processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_lead_reg  <= '0;
            payload_reg    <= '0;
            bytes_held_reg <= LEN_NONE;
            expected_reg   <= LEN_NONE;
            at_start_reg   <= 1'b1;
        end else if (step) begin
            held_lead_reg  <= held_lead_next;
            payload_reg    <= payload_next;
            bytes_held_reg <= bytes_held_next;
            expected_reg   <= expected_next;
            at_start_reg   <= at_start_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/u8dc_checker.sv]
// Port-level assertions for the UTF-8 decoder, bound to the top level.
`default_nettype none

module u8dc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire [20:0] m_codepoint,
    input wire [2:0]  m_seq_length,
    input wire        m_is_lower,
    input wire [20:0] m_upper_codepoint,
    input wire        m_first_of_text,
    input wire        m_last_of_text
);

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_codepoint)
        && $stable(m_upper_codepoint) && $stable(m_last_of_text))
        else $error("result word changed while stalled");

    // Length is always one to four
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_seq_length >= 3'd1) && (m_seq_length <= 3'd4))
        else $error("sequence length out of range");

    // Single-byte results carry the raw byte
    a_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_seq_length == 3'd1) |-> (m_codepoint[20:8] == 13'd0))
        else $error("single-byte result wider than a byte");

    // Case mapping changes the value exactly for lower-case letters
    a_case: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_lower == (m_upper_codepoint != m_codepoint)))
        else $error("lower flag disagrees with upper mapping");

    // The word after an end-of-text result starts a new text
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_text ##1 m_valid |-> m_first_of_text)
        else $error("text start not flagged after end of text");

endmodule

bind utf8_decoder_with_case u8dc_checker u_u8dc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_codepoint       (m_codepoint),
    .m_seq_length      (m_seq_length),
    .m_is_lower        (m_is_lower),
    .m_upper_codepoint (m_upper_codepoint),
    .m_first_of_text   (m_first_of_text),
    .m_last_of_text    (m_last_of_text)
);

`default_nettype wire
